/* rtl/core/scp_pkg.sv */
// Shared types, constants and helpers for the command line parser.
// No dependencies; imported by every module of the block.
package scp_pkg;

    localparam int DEF_VERB_BYTES = 16;
    localparam int DEF_ARG_BYTES  = 256;

    localparam int VERB_KEEP = 4;

    localparam logic [7:0] CH_SP = 8'h20;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    localparam logic [VERB_KEEP-1:0][7:0] KW_DATA = {8'h41, 8'h54, 8'h41, 8'h44};
    localparam logic [VERB_KEEP-1:0][7:0] KW_RSET = {8'h54, 8'h45, 8'h53, 8'h52};
    localparam logic [VERB_KEEP-1:0][7:0] KW_NOOP = {8'h50, 8'h4F, 8'h4F, 8'h4E};

    typedef enum logic [4:0] {
        ST_VERB = 5'b00001,
        ST_ARG  = 5'b00010,
        ST_CR   = 5'b00100,
        ST_DONE = 5'b01000,
        ST_ERR  = 5'b10000
    } state_t;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_DATA = 2'd1,
        KIND_RSET = 2'd2,
        KIND_NOOP = 2'd3
    } kind_t;

    localparam logic [2:0] CODE_VERB = 3'd0;
    localparam logic [2:0] CODE_ARG  = 3'd1;
    localparam logic [2:0] CODE_CR   = 3'd2;
    localparam logic [2:0] CODE_DONE = 3'd3;
    localparam logic [2:0] CODE_ERR  = 3'd4;

    typedef struct packed {
        logic [2:0] state_code;
        kind_t      verb_kind;
        logic       arg_byte_valid;
        logic [7:0] arg_byte;
        logic [3:0] verb_length;
        logic [7:0] arg_length;
        logic       finished;
        logic       failed;
    } result_t;

    function automatic logic [2:0] state_code_of(input state_t st);
        logic [2:0] code;
        unique case (st)
            ST_VERB: code = CODE_VERB;
            ST_ARG:  code = CODE_ARG;
            ST_CR:   code = CODE_CR;
            ST_DONE: code = CODE_DONE;
            ST_ERR:  code = CODE_ERR;
            default: code = CODE_ERR;
        endcase
        return code;
    endfunction

    function automatic logic [7:0] fold_upper(input logic [7:0] b);
        logic [7:0] r;
        if (b >= 8'h61 && b <= 8'h7A)
        begin
            r = b - 8'd32;
        end
        else
        begin
            r = b;
        end
        return r;
    endfunction

endpackage

/* rtl/core/scp_verb_match.sv */
// Case-insensitive compare of the first verb bytes against DATA, RSET, NOOP.
// Depends on scp_pkg.
module scp_verb_match (
    input  logic [scp_pkg::VERB_KEEP-1:0][7:0] verb_bytes,
    output scp_pkg::kind_t                     kind
);
    import scp_pkg::*;

    logic [VERB_KEEP-1:0][7:0] folded;

    always_comb
    begin
        for (int i = 0; i < VERB_KEEP; i++)
        begin
            folded[i] = fold_upper(verb_bytes[i]);
        end
    end

    always_comb
    begin
        priority if (folded == KW_DATA)
        begin
            kind = KIND_DATA;
        end
        else if (folded == KW_RSET)
        begin
            kind = KIND_RSET;
        end
        else if (folded == KW_NOOP)
        begin
            kind = KIND_NOOP;
        end
        else
        begin
            kind = KIND_NONE;
        end
    end

endmodule

/* rtl/core/scp_step.sv */
// Next-state and result logic for one byte of the command line.
// Depends on scp_pkg and scp_verb_match.
module scp_step #(
    parameter int VERB_BYTES = scp_pkg::DEF_VERB_BYTES,
    parameter int ARG_BYTES  = scp_pkg::DEF_ARG_BYTES,
    parameter int VW         = $clog2(VERB_BYTES),
    parameter int AW         = $clog2(ARG_BYTES)
) (
    input  logic [7:0]                          byte_in,
    input  logic                                restart,
    input  scp_pkg::state_t                     state_cur,
    input  logic [VW-1:0]                       verb_cnt,
    input  logic [AW-1:0]                       arg_cnt,
    input  logic [scp_pkg::VERB_KEEP-1:0][7:0]  verb_bytes,
    output scp_pkg::state_t                     state_nxt,
    output logic [VW-1:0]                       verb_cnt_nxt,
    output logic [AW-1:0]                       arg_cnt_nxt,
    output logic [scp_pkg::VERB_KEEP-1:0][7:0]  verb_bytes_nxt,
    output scp_pkg::result_t                    res
);
    import scp_pkg::*;

    localparam logic [VW-1:0] VERB_LAST = VW'(VERB_BYTES - 1);
    localparam logic [AW-1:0] ARG_LAST  = AW'(ARG_BYTES - 1);
    localparam logic [VW-1:0] KEEP_LIM  = VW'(VERB_KEEP);

    kind_t             match_kind;
    kind_t             kind;
    logic              avalid;
    logic [7:0]        abyte;
    logic [VW+3:0]     verb_len_ext;
    logic [AW+7:0]     arg_len_ext;

    scp_verb_match u_match (
        .verb_bytes (verb_bytes),
        .kind       (match_kind)
    );

    always_comb
    begin
        state_nxt      = state_cur;
        verb_cnt_nxt   = verb_cnt;
        arg_cnt_nxt    = arg_cnt;
        verb_bytes_nxt = verb_bytes;
        kind           = KIND_NONE;
        avalid         = 1'b0;
        abyte          = 8'h00;
        if (restart)
        begin
            state_nxt      = ST_VERB;
            verb_cnt_nxt   = '0;
            arg_cnt_nxt    = '0;
            verb_bytes_nxt = '0;
        end
        else
        begin
            unique case (state_cur)
                ST_VERB:
                begin
                    priority if (byte_in == CH_SP)
                    begin
                        state_nxt = ST_ARG;
                    end
                    else if (byte_in == CH_CR)
                    begin
                        if (match_kind != KIND_NONE)
                        begin
                            kind      = match_kind;
                            state_nxt = ST_CR;
                        end
                        else
                        begin
                            state_nxt = ST_ERR;
                        end
                    end
                    else if (verb_cnt < VERB_LAST)
                    begin
                        if (verb_cnt < KEEP_LIM)
                        begin
                            verb_bytes_nxt[verb_cnt[1:0]] = byte_in;
                        end
                        verb_cnt_nxt = verb_cnt + VW'(1);
                    end
                    else
                    begin
                        state_nxt = ST_ERR;
                    end
                end
                ST_ARG:
                begin
                    priority if (byte_in == CH_CR)
                    begin
                        state_nxt = ST_CR;
                    end
                    else if (arg_cnt < ARG_LAST)
                    begin
                        arg_cnt_nxt = arg_cnt + AW'(1);
                        avalid      = 1'b1;
                        abyte       = byte_in;
                    end
                    else
                    begin
                        state_nxt = ST_ERR;
                    end
                end
                ST_CR:
                begin
                    state_nxt = (byte_in == CH_LF) ? ST_DONE : ST_ERR;
                end
                ST_DONE, ST_ERR:
                begin
                    state_nxt = ST_ERR;
                end
                default:
                begin
                    state_nxt = ST_ERR;
                end
            endcase
        end
    end

    assign verb_len_ext = {4'b0, verb_cnt_nxt};
    assign arg_len_ext  = {8'b0, arg_cnt_nxt};

    always_comb
    begin
        res.state_code     = state_code_of(state_nxt);
        res.verb_kind      = kind;
        res.arg_byte_valid = avalid;
        res.arg_byte       = abyte;
        res.verb_length    = verb_len_ext[3:0];
        res.arg_length     = arg_len_ext[7:0];
        res.finished       = (state_nxt == ST_DONE) || (state_nxt == ST_ERR);
        res.failed         = (state_nxt == ST_ERR);
    end

endmodule

/* rtl/core/smtp_command_line_parser.sv */
// Top level of the command line parser: input register, parser state, result register.
// Depends on scp_pkg and scp_step.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one byte_in per transfer, with a
//   restart flag that clears the parser for a new line and ignores the byte.
//   Output channel (out_valid/out_ready) carries one result per input transfer:
//   state code, matched verb, stored argument byte, lengths, finished, failed.
//   A byte taken is held in the input register until the parser update moves its
//   result into the result register, from which the result transfer is made.
//   Throughput: one byte per cycle while out_ready stays high; the parser state
//   update is a single registered step, so bytes flow back to back.
//   Stall: while out_ready is low the result holds, the input register fills,
//   and in_ready drops once both stages hold a transfer. No result is lost.
//   Reset: rst_n clears both stages and puts the parser in the verb state with
//   zero counts and a cleared verb buffer.
module smtp_command_line_parser #(
    parameter int VERB_BYTES = scp_pkg::DEF_VERB_BYTES,
    parameter int ARG_BYTES  = scp_pkg::DEF_ARG_BYTES
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] byte_in,
    input  logic       restart,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] state_code,
    output logic [1:0] verb_kind,
    output logic       arg_byte_valid,
    output logic [7:0] arg_byte,
    output logic [3:0] verb_length,
    output logic [7:0] arg_length,
    output logic       finished,
    output logic       failed
);
    import scp_pkg::*;

    localparam int VW = $clog2(VERB_BYTES);
    localparam int AW = $clog2(ARG_BYTES);

    logic                      in_valid_reg;
    logic [7:0]                in_byte_reg;
    logic                      in_restart_reg;
    state_t                    state_reg;
    state_t                    state_next;
    logic [VW-1:0]             verb_cnt_reg;
    logic [VW-1:0]             verb_cnt_next;
    logic [AW-1:0]             arg_cnt_reg;
    logic [AW-1:0]             arg_cnt_next;
    logic [VERB_KEEP-1:0][7:0] verb_bytes_reg;
    logic [VERB_KEEP-1:0][7:0] verb_bytes_next;
    logic                      out_valid_reg;
    result_t                   res_reg;
    result_t                   res_next;
    logic                      out_free;
    logic                      advance;

    assign out_free = !out_valid_reg || out_ready;
    assign advance  = in_valid_reg && out_free;
    assign in_ready = !in_valid_reg || out_free;

    scp_step #(
        .VERB_BYTES (VERB_BYTES),
        .ARG_BYTES  (ARG_BYTES),
        .VW         (VW),
        .AW         (AW)
    ) u_step (
        .byte_in        (in_byte_reg),
        .restart        (in_restart_reg),
        .state_cur      (state_reg),
        .verb_cnt       (verb_cnt_reg),
        .arg_cnt        (arg_cnt_reg),
        .verb_bytes     (verb_bytes_reg),
        .state_nxt      (state_next),
        .verb_cnt_nxt   (verb_cnt_next),
        .arg_cnt_nxt    (arg_cnt_next),
        .verb_bytes_nxt (verb_bytes_next),
        .res            (res_next)
    );

    // hold the input transfer until the parser stage takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg    <= byte_in;
            in_restart_reg <= restart;
        end
    end

    // advance parser state once per byte moved into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_VERB;
            verb_cnt_reg   <= '0;
            arg_cnt_reg    <= '0;
            verb_bytes_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance)
            begin
                state_reg      <= state_next;
                verb_cnt_reg   <= verb_cnt_next;
                arg_cnt_reg    <= arg_cnt_next;
                verb_bytes_reg <= verb_bytes_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign state_code     = res_reg.state_code;
    assign verb_kind      = res_reg.verb_kind;
    assign arg_byte_valid = res_reg.arg_byte_valid;
    assign arg_byte       = res_reg.arg_byte;
    assign verb_length    = res_reg.verb_length;
    assign arg_length     = res_reg.arg_length;
    assign finished       = res_reg.finished;
    assign failed         = res_reg.failed;

`ifndef SYNTHESIS
    a_failed_finished : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && failed) |-> finished)
        else $error("failed result without finished");

    a_arg_in_arg_state : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && arg_byte_valid) |-> (state_code == CODE_ARG))
        else $error("argument byte outside argument state");

    a_kind_at_cr : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (verb_kind != KIND_NONE)) |-> (state_code == CODE_CR))
        else $error("verb kind reported outside verb CR");

    a_err_sticky : assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (state_reg == ST_ERR) && !in_restart_reg) |=> (state_reg == ST_ERR))
        else $error("error state left without restart");
`endif

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for smtp_command_line_parser: byte stream in, one result per byte.
// Depends on scp_pkg for the keyword constants, delimiters, state codes and the result type.
// A queue-fed driver and a clocked monitor compare every result against a local parser model.
module testbench;
    import scp_pkg::*;

    localparam int VERB_BYTES  = DEF_VERB_BYTES;
    localparam int ARG_BYTES   = DEF_ARG_BYTES;
    localparam int STIM_TARGET = 930;
    localparam int SEGMENTS    = 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PRINT_CAP   = 40;

    localparam logic [VERB_KEEP-1:0][7:0] KEYWORDS [3] = '{KW_DATA, KW_RSET, KW_NOOP};
    localparam kind_t KEYWORD_KINDS [3] = '{KIND_DATA, KIND_RSET, KIND_NOOP};

    typedef enum int {
        PH_STEADY,
        PH_TX_IDLE,
        PH_RX_STALL,
        PH_BOTH
    } pace_t;

    typedef struct {
        logic [7:0] value;
        logic       rs;
    } line_byte_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] byte_in = 8'h00;
    logic       restart = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [2:0] state_code;
    logic [1:0] verb_kind;
    logic       arg_byte_valid;
    logic [7:0] arg_byte;
    logic [3:0] verb_length;
    logic [7:0] arg_length;
    logic       finished;
    logic       failed;

    line_byte_t  pending_bytes [$];
    result_t     expected_results [$];
    result_t     oldest_result;
    logic        in_taken = 1'b0;
    int          total_bytes = 1;
    int          sent_count = 0;
    int          open_seg = 0;
    int          cur_seg;
    pace_t       pace;
    int          error_count = 0;
    int          cycle_count = 0;

    logic [2:0]  line_state;
    int unsigned fill_pos;
    int unsigned verb_seen;
    int unsigned arg_seen;
    logic [7:0]  verb_buf [VERB_BYTES];

    smtp_command_line_parser dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .byte_in(byte_in),
        .restart(restart),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .state_code(state_code),
        .verb_kind(verb_kind),
        .arg_byte_valid(arg_byte_valid),
        .arg_byte(arg_byte),
        .verb_length(verb_length),
        .arg_length(arg_length),
        .finished(finished),
        .failed(failed)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_CAP)
        begin
            $display("ERROR at cycle %0d: %s", cycle_count, msg);
        end
        error_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
        begin
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
        end
    endtask

    function automatic void clear_parser();
        line_state = CODE_VERB;
        fill_pos   = 0;
        verb_seen  = 0;
        arg_seen   = 0;
        foreach (verb_buf[i])
        begin
            verb_buf[i] = 8'h00;
        end
    endfunction

    function automatic result_t parse_byte(input logic [7:0] b, input logic rs);
        result_t    r;
        logic [2:0] nxt;
        kind_t      kind;
        logic [7:0] c;
        logic       same;
        r    = '0;
        kind = KIND_NONE;
        nxt  = line_state;
        if (rs)
        begin
            clear_parser();
            nxt = CODE_VERB;
        end
        else
        begin
            case (line_state)
                CODE_VERB:
                begin
                    if (b == CH_SP)
                    begin
                        if (fill_pos < VERB_BYTES)
                        begin
                            verb_buf[fill_pos] = 8'h00;
                        end
                        fill_pos = 0;
                        nxt = CODE_ARG;
                    end
                    else if (b == CH_CR)
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            same = 1'b1;
                            for (int j = 0; j < VERB_KEEP; j++)
                            begin
                                c = verb_buf[j];
                                if (c >= "a" && c <= "z")
                                begin
                                    c = c - 8'd32;
                                end
                                if (c != KEYWORDS[k][j])
                                begin
                                    same = 1'b0;
                                end
                            end
                            if (same && kind == KIND_NONE)
                            begin
                                kind = KEYWORD_KINDS[k];
                            end
                        end
                        if (kind != KIND_NONE)
                        begin
                            if (fill_pos < VERB_BYTES)
                            begin
                                verb_buf[fill_pos] = 8'h00;
                            end
                            fill_pos = 0;
                            nxt = CODE_CR;
                        end
                        else
                        begin
                            nxt = CODE_ERR;
                        end
                    end
                    else if (fill_pos < VERB_BYTES - 1)
                    begin
                        verb_buf[fill_pos] = b;
                        fill_pos++;
                        verb_seen++;
                        nxt = CODE_VERB;
                    end
                    else
                    begin
                        nxt = CODE_ERR;
                    end
                end
                CODE_ARG:
                begin
                    if (b == CH_CR)
                    begin
                        nxt = CODE_CR;
                    end
                    else if (fill_pos < ARG_BYTES - 1)
                    begin
                        fill_pos++;
                        arg_seen++;
                        r.arg_byte_valid = 1'b1;
                        r.arg_byte = b;
                        nxt = CODE_ARG;
                    end
                    else
                    begin
                        nxt = CODE_ERR;
                    end
                end
                CODE_CR:
                begin
                    nxt = (b == CH_LF) ? CODE_DONE : CODE_ERR;
                end
                default:
                begin
                    nxt = CODE_ERR;
                end
            endcase
            line_state = nxt;
        end
        r.state_code  = line_state;
        r.verb_kind   = kind;
        r.verb_length = verb_seen[3:0];
        r.arg_length  = arg_seen[7:0];
        r.finished    = (line_state == CODE_DONE) || (line_state == CODE_ERR);
        r.failed      = (line_state == CODE_ERR);
        return r;
    endfunction

    task automatic queue_byte(input logic [7:0] value, input logic rs);
        line_byte_t item;
        item.value = value;
        item.rs    = rs;
        pending_bytes.push_back(item);
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            queue_byte(s[i], 1'b0);
        end
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (c == CH_SP || c == CH_CR)
        begin
            c = 8'($urandom_range(0, 255));
        end
        return c;
    endfunction

    function automatic logic [7:0] arg_pick();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (c == CH_CR)
        begin
            c = 8'($urandom_range(0, 255));
        end
        return c;
    endfunction

    function automatic logic [7:0] noise_byte();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 5))
            0: c = CH_CR;
            1: c = CH_LF;
            2: c = CH_SP;
            default: ;
        endcase
        return c;
    endfunction

    // tail 0: clean LF, 1: random byte in place of LF, 2: LF then trailing bytes
    task automatic queue_command(input int arg_len, input int tail);
        int         k;
        logic       verb_cr;
        logic [7:0] c;
        queue_byte(8'($urandom_range(0, 255)), 1'b1);
        k = $urandom_range(0, 3);
        verb_cr = 1'b0;
        if (k == 3)
        begin
            repeat ($urandom_range(1, 14)) queue_byte(plain_byte(), 1'b0);
        end
        else
        begin
            for (int j = 0; j < VERB_KEEP; j++)
            begin
                c = KEYWORDS[k][j];
                if ($urandom_range(0, 1))
                begin
                    c = c | 8'h20;
                end
                queue_byte(c, 1'b0);
            end
            if ($urandom_range(0, 3) == 0)
            begin
                repeat ($urandom_range(1, 4)) queue_byte(plain_byte(), 1'b0);
            end
            verb_cr = $urandom_range(0, 1) && arg_len <= 12;
        end
        if (!verb_cr)
        begin
            queue_byte(CH_SP, 1'b0);
            repeat (arg_len) queue_byte(arg_pick(), 1'b0);
        end
        queue_byte(CH_CR, 1'b0);
        if (tail == 1)
        begin
            queue_byte(noise_byte(), 1'b0);
        end
        else
        begin
            queue_byte(CH_LF, 1'b0);
            if (tail == 2)
            begin
                repeat ($urandom_range(1, 3)) queue_byte(noise_byte(), 1'b0);
            end
        end
    endtask

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            cur_seg = (sent_count * SEGMENTS) / total_bytes;
            if (cur_seg != open_seg && expected_results.size() == 0)
            begin
                open_seg = cur_seg;
            end
            pace = pace_t'(open_seg % 4);
            case (pace)
                PH_RX_STALL: out_ready <= ($urandom_range(0, 99) >= 48);
                PH_BOTH:     out_ready <= ($urandom_range(0, 99) >= 19);
                default:     out_ready <= 1'b1;
            endcase
            if (!in_valid || in_taken)
            begin
                if (pending_bytes.size() != 0 && cur_seg == open_seg
                    && !(pace == PH_TX_IDLE && $urandom_range(0, 99) < 48)
                    && !(pace == PH_BOTH && $urandom_range(0, 99) < 19))
                begin
                    byte_in  <= pending_bytes[0].value;
                    restart  <= pending_bytes[0].rs;
                    in_valid <= 1'b1;
                    void'(pending_bytes.pop_front());
                    sent_count++;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_taken <= in_valid && in_ready;
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("result transfer with nothing expected");
                end
                else
                begin
                    oldest_result = expected_results.pop_front();
                    check_field("state_code", state_code, oldest_result.state_code);
                    check_field("verb_kind", verb_kind, oldest_result.verb_kind);
                    check_field("arg_byte_valid", arg_byte_valid, oldest_result.arg_byte_valid);
                    check_field("arg_byte", arg_byte, oldest_result.arg_byte);
                    check_field("verb_length", verb_length, oldest_result.verb_length);
                    check_field("arg_length", arg_length, oldest_result.arg_length);
                    check_field("finished", finished, oldest_result.finished);
                    check_field("failed", failed, oldest_result.failed);
                end
            end
            if (in_valid && in_ready)
            begin
                expected_results.push_back(parse_byte(byte_in, restart));
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("smtp_command_line_parser regression: fail");
        $finish;
    end

    initial
    begin
        int line_no;
        int roll;
        clear_parser();

        queue_byte(8'hFF, 1'b1);
        queue_text("noOp");
        queue_byte(CH_CR, 1'b0);
        queue_byte(CH_LF, 1'b0);
        queue_text("X");
        queue_byte(8'h00, 1'b1);
        queue_text("RSET");
        queue_byte(CH_SP, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(CH_CR, 1'b0);
        queue_byte(CH_LF, 1'b0);
        queue_byte(8'h5A, 1'b1);
        queue_text("DA");
        queue_byte(CH_CR, 1'b0);
        queue_text("A");
        queue_byte(8'hA5, 1'b1);
        queue_text("data");
        queue_byte(CH_CR, 1'b0);
        queue_text("Z");

        line_no = 0;
        while (pending_bytes.size() < STIM_TARGET)
        begin
            roll = $urandom_range(0, 99);
            if (line_no == 6)
            begin
                queue_command(ARG_BYTES - 1, 0);
            end
            else if (line_no == 16)
            begin
                queue_command(ARG_BYTES, 0);
            end
            else if (roll < 60)
            begin
                queue_command($urandom_range(0, 12), 0);
            end
            else if (roll < 68)
            begin
                queue_byte(8'($urandom_range(0, 255)), 1'b1);
                repeat ($urandom_range(VERB_BYTES - 2, VERB_BYTES + 1))
                    queue_byte(plain_byte(), 1'b0);
                queue_byte(CH_CR, 1'b0);
                queue_byte(CH_LF, 1'b0);
            end
            else if (roll < 78)
            begin
                queue_command($urandom_range(0, 6), $urandom_range(1, 2));
            end
            else
            begin
                repeat ($urandom_range(1, 8))
                    queue_byte(noise_byte(), $urandom_range(0, 7) == 0);
            end
            line_no++;
        end
        total_bytes = pending_bytes.size();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || in_valid || expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        end
        if (error_count == 0)
        begin
            $display("smtp_command_line_parser regression: pass");
        end
        else
        begin
            $display("smtp_command_line_parser regression: fail");
        end
        $finish;
    end

endmodule
